/* rtl/sgpm_pkg.sv */
// Shared constants, types and codes for the smoothed gain and peak meter unit.
// No dependencies; the RTL files refer to it by scoped names, the testbench files import it.
package sgpm_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int PEAK_BITS      = SAMPLE_BITS - 1;
  localparam int GAIN_BITS      = 28;
  localparam int GAIN_FRAC      = 24;
  localparam int TARGET_BITS    = 16;
  localparam int TARGET_FRAC    = 12;
  localparam int DECAY_BITS     = 24;
  localparam int DECAY_FRAC     = 24;
  localparam int COUNT_BITS     = 13;
  localparam int MAX_BLOCK      = 4096;
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 24;

  // smoother: g = floor((99*g + target_q4_24 + 50) / 100)
  localparam int SMOOTH_MUL = 99;
  localparam int DIV_CONST  = 100;
  localparam int ROUND_BIAS = 50;
  localparam int NUM_BITS   = 35;
  localparam int REM_BITS   = $clog2(DIV_CONST);

  localparam int GAIN_CNT_BITS  = $clog2(NUM_BITS);
  localparam int DECAY_CNT_BITS = $clog2(DECAY_BITS);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SAMPLE_BITS-1:0]        mag_t;
  typedef logic [PEAK_BITS-1:0]          peak_t;
  typedef logic [GAIN_BITS-1:0]          gain_t;
  typedef logic [GAIN_BITS:0]            gsum_t;
  typedef logic [NUM_BITS-1:0]           num_t;
  typedef logic [REM_BITS-1:0]           rem_t;
  typedef logic [REM_BITS:0]             rem_shift_t;
  typedef logic [TARGET_BITS-1:0]        target_t;
  typedef logic [DECAY_BITS-1:0]         decay_t;
  typedef logic [DECAY_BITS:0]           dsum_t;
  typedef logic [PEAK_BITS:0]            msum_t;
  typedef logic [COUNT_BITS-1:0]         count_t;
  typedef logic [GAIN_CNT_BITS-1:0]      gcnt_t;
  typedef logic [DECAY_CNT_BITS-1:0]     dcnt_t;
  typedef logic [CFG_INDEX_BITS-1:0]     cfg_index_t;
  typedef logic [CFG_DATA_BITS-1:0]      cfg_data_t;

  localparam target_t TARGET_RESET = target_t'(4096);
  localparam decay_t  DECAY_RESET  = decay_t'(3495);
  localparam gain_t   GAIN_RESET   = gain_t'(TARGET_RESET) << (GAIN_FRAC - TARGET_FRAC);
  localparam gsum_t   SAT_HALF     = gsum_t'(1) << (SAMPLE_BITS - 1);
  localparam gsum_t   SAT_POS      = SAT_HALF - gsum_t'(1);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TARGET_GAIN      = 1'b0,
    REG_DECAY_PER_SAMPLE = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } top_state_t;

  typedef enum logic [1:0] {
    GP_IDLE,
    GP_DIV,
    GP_MUL,
    GP_SAT
  } gain_phase_t;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_COUNT,
    DP_LOAD,
    DP_SCALE,
    DP_FIN
  } decay_phase_t;

  typedef struct packed {
    logic busy;
    logic valid;
  } unit_status_t;

endpackage

/* rtl/sgpm_ifs.sv */
// Valid/ready channel interfaces: audio words in, result words out, config writes.
// Depends on sgpm_pkg for payload types.
interface sgpm_audio_if;
  logic               valid;
  logic               ready;
  sgpm_pkg::sample_t  sample_in;
  logic               block_last;
  modport source (output valid, output sample_in, output block_last, input ready);
  modport sink   (input valid, input sample_in, input block_last, output ready);
endinterface

interface sgpm_result_if;
  logic               valid;
  logic               ready;
  sgpm_pkg::sample_t  sample_out;
  sgpm_pkg::peak_t    meter_level;
  logic               block_done;
  modport source (output valid, output sample_out, output meter_level, output block_done,
                  input ready);
  modport sink   (input valid, input sample_out, input meter_level, input block_done,
                  output ready);
endinterface

interface sgpm_cfg_if;
  logic                  valid;
  logic                  ready;
  sgpm_pkg::cfg_index_t  index;
  sgpm_pkg::cfg_data_t   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/sgpm_gain.sv */
// Gain path: one-pole smoother (bit-serial divide by 100), bit-serial
// sample-by-gain multiply, rounding and saturation. Depends on sgpm_pkg.
module sgpm_gain (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  sgpm_pkg::sample_t      sample_in,
  input  sgpm_pkg::target_t      target_gain,
  output sgpm_pkg::unit_status_t status,
  output sgpm_pkg::sample_t      sample_out,
  output sgpm_pkg::peak_t        peak_abs
);

  sgpm_pkg::gain_phase_t phase, phase_next;
  sgpm_pkg::gain_t       g;
  sgpm_pkg::num_t        num;
  sgpm_pkg::num_t        num_init;
  sgpm_pkg::rem_t        rem;
  sgpm_pkg::rem_t        rem_next;
  sgpm_pkg::rem_shift_t  rem_shift;
  logic                  quo_bit;
  sgpm_pkg::gcnt_t       cnt;
  sgpm_pkg::mag_t        mag_in;
  sgpm_pkg::mag_t        lo;
  sgpm_pkg::gain_t       hi;
  sgpm_pkg::gsum_t       acc_sum;
  sgpm_pkg::gsum_t       rounded;
  sgpm_pkg::gsum_t       clipped;
  sgpm_pkg::sample_t     sat_value;
  sgpm_pkg::peak_t       sat_abs;
  logic                  neg;
  logic                  valid;

  assign num_init = sgpm_pkg::num_t'(g) * sgpm_pkg::num_t'(sgpm_pkg::SMOOTH_MUL)
                  + sgpm_pkg::num_t'({target_gain,
                                      {(sgpm_pkg::GAIN_FRAC - sgpm_pkg::TARGET_FRAC){1'b0}}})
                  + sgpm_pkg::num_t'(sgpm_pkg::ROUND_BIAS);

  assign mag_in = sample_in[sgpm_pkg::SAMPLE_BITS-1] ? sgpm_pkg::mag_t'(-sample_in)
                                                      : sgpm_pkg::mag_t'(sample_in);

  // restoring divide by 100, one quotient bit per cycle
  assign rem_shift = {rem, num[sgpm_pkg::NUM_BITS-1]};
  assign quo_bit   = (rem_shift >= sgpm_pkg::rem_shift_t'(sgpm_pkg::DIV_CONST));
  assign rem_next  = quo_bit ? sgpm_pkg::rem_t'(rem_shift -
                                                sgpm_pkg::rem_shift_t'(sgpm_pkg::DIV_CONST))
                             : rem_shift[sgpm_pkg::REM_BITS-1:0];

  // shift-add multiply, LSB of the magnitude first
  assign acc_sum = {1'b0, hi} + (lo[0] ? {1'b0, g} : sgpm_pkg::gsum_t'(0));

  // round half away from zero, then saturate
  assign rounded = {1'b0, hi} + sgpm_pkg::gsum_t'(lo[sgpm_pkg::SAMPLE_BITS-1]);

  always_comb begin
    if (neg) begin
      clipped   = (rounded > sgpm_pkg::SAT_HALF) ? sgpm_pkg::SAT_HALF : rounded;
      sat_value = sgpm_pkg::sample_t'(sgpm_pkg::gsum_t'(0) - clipped);
    end else begin
      clipped   = (rounded > sgpm_pkg::SAT_POS) ? sgpm_pkg::SAT_POS : rounded;
      sat_value = sgpm_pkg::sample_t'(clipped);
    end
    sat_abs = (clipped > sgpm_pkg::SAT_POS) ? sgpm_pkg::peak_t'(sgpm_pkg::SAT_POS)
                                            : sgpm_pkg::peak_t'(clipped);
  end

  always_comb begin
    phase_next = phase;
    unique case (phase)
      sgpm_pkg::GP_IDLE: if (start) phase_next = sgpm_pkg::GP_DIV;
      sgpm_pkg::GP_DIV:  if (cnt == '0) phase_next = sgpm_pkg::GP_MUL;
      sgpm_pkg::GP_MUL:  if (cnt == '0) phase_next = sgpm_pkg::GP_SAT;
      sgpm_pkg::GP_SAT:  phase_next = sgpm_pkg::GP_IDLE;
    endcase
  end

  always_comb begin
    status.busy  = (phase != sgpm_pkg::GP_IDLE);
    status.valid = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sgpm_pkg::GP_IDLE;
      g     <= sgpm_pkg::GAIN_RESET;
      valid <= 1'b0;
    end else begin
      phase <= phase_next;
      unique case (phase)
        sgpm_pkg::GP_IDLE: begin
          if (start) begin
            num   <= num_init;
            rem   <= '0;
            cnt   <= sgpm_pkg::gcnt_t'(sgpm_pkg::NUM_BITS - 1);
            lo    <= mag_in;
            neg   <= sample_in[sgpm_pkg::SAMPLE_BITS-1];
            valid <= 1'b0;
          end
        end
        sgpm_pkg::GP_DIV: begin
          rem <= rem_next;
          num <= {num[sgpm_pkg::NUM_BITS-2:0], quo_bit};
          cnt <= cnt - sgpm_pkg::gcnt_t'(1);
          if (cnt == '0) begin
            g   <= {num[sgpm_pkg::GAIN_BITS-2:0], quo_bit};
            hi  <= '0;
            cnt <= sgpm_pkg::gcnt_t'(sgpm_pkg::SAMPLE_BITS - 1);
          end
        end
        sgpm_pkg::GP_MUL: begin
          hi  <= acc_sum[sgpm_pkg::GAIN_BITS:1];
          lo  <= {acc_sum[0], lo[sgpm_pkg::SAMPLE_BITS-1:1]};
          cnt <= cnt - sgpm_pkg::gcnt_t'(1);
        end
        sgpm_pkg::GP_SAT: begin
          sample_out <= sat_value;
          peak_abs   <= sat_abs;
          valid      <= 1'b1;
        end
      endcase
    end
  end

endmodule

/* rtl/sgpm_decay.sv */
// Meter decay: bit-serial count * decay_per_sample, then bit-serial
// meter * decay with full-decay clamp. Depends on sgpm_pkg.
module sgpm_decay (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  sgpm_pkg::count_t       count,
  input  sgpm_pkg::decay_t       decay_per_sample,
  input  sgpm_pkg::peak_t        meter_value,
  output sgpm_pkg::unit_status_t status,
  output sgpm_pkg::peak_t        meter_decayed
);

  sgpm_pkg::decay_phase_t phase, phase_next;
  sgpm_pkg::dcnt_t        cnt;
  sgpm_pkg::decay_t       d_hi;
  sgpm_pkg::count_t       d_lo;
  sgpm_pkg::dsum_t        d_sum;
  sgpm_pkg::decay_t       d_sr;
  sgpm_pkg::peak_t        m_hi;
  sgpm_pkg::msum_t        m_sum;
  logic                   full;
  logic                   valid;

  localparam int HI_KEEP = sgpm_pkg::DECAY_FRAC - sgpm_pkg::COUNT_BITS;

  assign d_sum = {1'b0, d_hi} + (d_lo[0] ? {1'b0, decay_per_sample} : sgpm_pkg::dsum_t'(0));
  assign m_sum = {1'b0, m_hi} + (d_sr[0] ? {1'b0, meter_value} : sgpm_pkg::msum_t'(0));

  always_comb begin
    phase_next = phase;
    unique case (phase)
      sgpm_pkg::DP_IDLE:  if (start) phase_next = sgpm_pkg::DP_COUNT;
      sgpm_pkg::DP_COUNT: if (cnt == '0) phase_next = sgpm_pkg::DP_LOAD;
      sgpm_pkg::DP_LOAD:  phase_next = sgpm_pkg::DP_SCALE;
      sgpm_pkg::DP_SCALE: if (cnt == '0) phase_next = sgpm_pkg::DP_FIN;
      sgpm_pkg::DP_FIN:   phase_next = sgpm_pkg::DP_IDLE;
      default:            phase_next = sgpm_pkg::DP_IDLE;
    endcase
  end

  always_comb begin
    status.busy  = (phase != sgpm_pkg::DP_IDLE);
    status.valid = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= sgpm_pkg::DP_IDLE;
      valid <= 1'b0;
    end else begin
      phase <= phase_next;
      unique case (phase)
        sgpm_pkg::DP_IDLE: begin
          if (start) begin
            d_hi  <= '0;
            d_lo  <= count;
            cnt   <= sgpm_pkg::dcnt_t'(sgpm_pkg::COUNT_BITS - 1);
            valid <= 1'b0;
          end
        end
        sgpm_pkg::DP_COUNT: begin
          d_hi <= d_sum[sgpm_pkg::DECAY_BITS:1];
          d_lo <= {d_sum[0], d_lo[sgpm_pkg::COUNT_BITS-1:1]};
          cnt  <= cnt - sgpm_pkg::dcnt_t'(1);
        end
        sgpm_pkg::DP_LOAD: begin
          // product is {d_hi, d_lo}; at or above 1.0 the meter clears
          d_sr <= {d_hi[HI_KEEP-1:0], d_lo};
          full <= |d_hi[sgpm_pkg::DECAY_BITS-1:HI_KEEP];
          m_hi <= '0;
          cnt  <= sgpm_pkg::dcnt_t'(sgpm_pkg::DECAY_BITS - 1);
        end
        sgpm_pkg::DP_SCALE: begin
          m_hi <= m_sum[sgpm_pkg::PEAK_BITS:1];
          d_sr <= {m_sum[0], d_sr[sgpm_pkg::DECAY_BITS-1:1]};
          cnt  <= cnt - sgpm_pkg::dcnt_t'(1);
        end
        sgpm_pkg::DP_FIN: begin
          meter_decayed <= full ? sgpm_pkg::peak_t'(0) : meter_value - m_hi;
          valid         <= 1'b1;
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/smoothed_gain_with_peak_meter_unit.sv */
// Smoothed gain with block peak meter, top level.
// One word at a time: the next audio word is taken only once the result of the
// last one is committed, and the 35-step divide by 100 plus the 24-step serial
// multiply in sgpm_gain set how long that takes.
// The output register frees the input side while a result waits to be taken.
// Synchronous active-high rst: gain to unity, meter, peak and count to zero.
module smoothed_gain_with_peak_meter_unit (
  input  logic           clk,
  input  logic           rst,
  sgpm_audio_if.sink     audio,
  sgpm_result_if.source  result,
  sgpm_cfg_if.sink       cfg
);

  sgpm_pkg::top_state_t   state, state_next;
  sgpm_pkg::target_t      target_gain;
  sgpm_pkg::decay_t       decay_per_sample;
  sgpm_pkg::peak_t        block_peak;
  sgpm_pkg::peak_t        meter_value;
  sgpm_pkg::count_t       count;
  sgpm_pkg::count_t       count_inc;
  logic                   last_q;

  logic                   in_ready;
  logic                   start;
  logic                   commit;
  logic                   out_free;

  sgpm_pkg::unit_status_t gain_st;
  sgpm_pkg::unit_status_t decay_st;
  sgpm_pkg::sample_t      gain_sample;
  sgpm_pkg::peak_t        gain_abs;
  sgpm_pkg::peak_t        meter_decayed;
  sgpm_pkg::peak_t        peak_new;
  sgpm_pkg::peak_t        meter_new;

  logic                   out_valid;
  sgpm_pkg::sample_t      out_sample;
  sgpm_pkg::peak_t        out_meter;
  logic                   out_done;

  sgpm_gain u_gain (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .sample_in   (audio.sample_in),
    .target_gain (target_gain),
    .status      (gain_st),
    .sample_out  (gain_sample),
    .peak_abs    (gain_abs)
  );

  sgpm_decay u_decay (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .count            (count_inc),
    .decay_per_sample (decay_per_sample),
    .meter_value      (meter_value),
    .status           (decay_st),
    .meter_decayed    (meter_decayed)
  );

  assign count_inc = (count < sgpm_pkg::count_t'(sgpm_pkg::MAX_BLOCK))
                   ? count + sgpm_pkg::count_t'(1) : count;
  assign peak_new  = (gain_abs > block_peak) ? gain_abs : block_peak;
  assign meter_new = (peak_new > meter_decayed) ? peak_new : meter_decayed;
  assign out_free  = !out_valid || result.ready;

  assign audio.ready       = in_ready;
  assign cfg.ready         = 1'b1;
  assign result.valid      = out_valid;
  assign result.sample_out = out_sample;
  assign result.meter_level = out_meter;
  assign result.block_done = out_done;

  always_comb begin
    state_next = state;
    unique case (state)
      sgpm_pkg::ST_IDLE: if (audio.valid) state_next = sgpm_pkg::ST_BUSY;
      sgpm_pkg::ST_BUSY: if (commit) state_next = sgpm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    start    = 1'b0;
    commit   = 1'b0;
    unique case (state)
      sgpm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        start    = audio.valid;
      end
      sgpm_pkg::ST_BUSY: begin
        commit = gain_st.valid && decay_st.valid && out_free;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= sgpm_pkg::ST_IDLE;
      target_gain      <= sgpm_pkg::TARGET_RESET;
      decay_per_sample <= sgpm_pkg::DECAY_RESET;
      block_peak       <= '0;
      meter_value      <= '0;
      count            <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (sgpm_pkg::cfg_reg_t'(cfg.index))
          sgpm_pkg::REG_TARGET_GAIN:
            target_gain <= cfg.data[sgpm_pkg::TARGET_BITS-1:0];
          sgpm_pkg::REG_DECAY_PER_SAMPLE:
            decay_per_sample <= cfg.data[sgpm_pkg::DECAY_BITS-1:0];
        endcase
      end
      if (start) begin
        last_q <= audio.block_last;
      end
      if (commit) begin
        out_valid  <= 1'b1;
        out_sample <= gain_sample;
        out_done   <= last_q;
        if (last_q) begin
          meter_value <= meter_new;
          out_meter   <= meter_new;
          block_peak  <= '0;
          count       <= '0;
        end else begin
          out_meter  <= meter_value;
          block_peak <= peak_new;
          count      <= count_inc;
        end
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    commit |=> result.valid)
    else $error("result word not presented after commit");

  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    (gain_st.busy || decay_st.busy) |-> (state == sgpm_pkg::ST_BUSY))
    else $error("serial unit running with no word in flight");

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (commit && last_q) |=> (block_peak == '0 && count == '0))
    else $error("block state not cleared at block end");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= sgpm_pkg::count_t'(sgpm_pkg::MAX_BLOCK))
    else $error("sample count above block limit");

endmodule

/* tb/sv/sgpm_result_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the smoothed gain and peak meter unit: watches the audio, config and
// result channels, predicts each result word and compares it field by field.
// Depends on sgpm_pkg and the channel interfaces of sgpm_ifs.
module sgpm_result_checker (
  input  logic   clk,
  input  logic   rst,
  sgpm_audio_if  audio,
  sgpm_result_if result,
  sgpm_cfg_if    cfg,
  output int     mismatch_count,
  output int     words_in_flight
);
  import sgpm_pkg::*;

  typedef struct packed {
    sample_t sample;
    peak_t   meter;
    logic    done;
  } result_word_t;

  target_t      target_gain_q;
  decay_t       decay_q;
  gain_t        gain_q;
  peak_t        peak_q;
  peak_t        meter_q;
  count_t       count_q;
  result_word_t gained_words_due[$];
  int           fails = 0;

  function automatic result_word_t gain_and_meter(input sample_t s, input logic last);
    logic [63:0] half;
    logic [63:0] pos_max;
    logic [63:0] mag;
    logic [63:0] r;
    logic [63:0] d;
    logic        neg;
    sample_t     y;
    peak_t       a;
    half    = 64'd1 << (SAMPLE_BITS - 1);
    pos_max = half - 64'd1;
    neg     = s[SAMPLE_BITS-1];
    mag     = 64'(mag_t'(s));
    if (neg) mag = (64'd1 << SAMPLE_BITS) - mag;
    // one-pole smoother, 1% toward target per word
    gain_q = gain_t'((64'(gain_q) * 64'(SMOOTH_MUL)
                      + (64'(target_gain_q) << (GAIN_FRAC - TARGET_FRAC))
                      + 64'(ROUND_BIAS)) / 64'(DIV_CONST));
    r = (mag * 64'(gain_q) + (64'd1 << (GAIN_FRAC - 1))) >> GAIN_FRAC;
    if (neg) begin
      if (r > half) r = half;
      y = sample_t'(64'd0 - r);
      a = peak_t'((r > pos_max) ? pos_max : r);
    end else begin
      if (r > pos_max) r = pos_max;
      y = sample_t'(r);
      a = peak_t'(r);
    end
    if (a > peak_q) peak_q = a;
    if (count_q < count_t'(MAX_BLOCK)) count_q = count_q + 1'b1;
    if (last) begin
      d = 64'(count_q) * 64'(decay_q);
      if (d >= (64'd1 << DECAY_FRAC)) meter_q = '0;
      else meter_q = meter_q - peak_t'((64'(meter_q) * d) >> DECAY_FRAC);
      if (peak_q > meter_q) meter_q = peak_q;
      peak_q  = '0;
      count_q = '0;
    end
    return '{sample: y, meter: meter_q, done: last};
  endfunction

  always @(posedge clk) begin : watch
    result_word_t exp_w;
    if (rst) begin
      target_gain_q = TARGET_RESET;
      decay_q       = DECAY_RESET;
      gain_q        = GAIN_RESET;
      peak_q        = '0;
      meter_q       = '0;
      count_q       = '0;
      gained_words_due.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_TARGET_GAIN:      target_gain_q = target_t'(cfg.data);
          REG_DECAY_PER_SAMPLE: decay_q       = decay_t'(cfg.data);
          default: ;
        endcase
      end
      if (audio.valid && audio.ready)
        gained_words_due.push_back(gain_and_meter(audio.sample_in, audio.block_last));
      if (result.valid && result.ready) begin
        if (gained_words_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result word with none expected: sample_out %0d meter_level %0d",
                     $time, result.sample_out, result.meter_level);
        end else begin
          exp_w = gained_words_due.pop_front();
          if (exp_w.sample !== result.sample_out || exp_w.meter !== result.meter_level ||
              exp_w.done !== result.block_done) begin
            fails++;
            if (fails <= 10)
              $display("%0t: exp/got sample_out %0d/%0d meter_level %0d/%0d block_done %0b/%0b",
                       $time, exp_w.sample, result.sample_out, exp_w.meter,
                       result.meter_level, exp_w.done, result.block_done);
          end
        end
      end
    end
    mismatch_count  <= fails;
    words_in_flight <= gained_words_due.size();
  end

endmodule

/* tb/sv/smoothed_gain_with_peak_meter_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the smoothed gain and peak meter unit: clock, reset, audio and
// config stimulus, result pacing and verdict. Depends on sgpm_pkg, sgpm_ifs, the unit
// and sgpm_result_checker.
module smoothed_gain_with_peak_meter_unit_tb;
  import sgpm_pkg::*;

  localparam int      RANDOM_PHASES  = 8;
  localparam int      PHASE_WORDS    = 144;
  localparam int      LONG_HOLD      = 600;
  localparam sample_t SAMPLE_MAX     = sample_t'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam sample_t SAMPLE_MIN     = sample_t'(1 << (SAMPLE_BITS - 1));

  typedef enum int {PACE_OPEN, PACE_COIN, PACE_SPARSE, PACE_SHUT} pace_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic hold_long = 1'b0;
  int   mismatch_count;
  int   words_in_flight;
  int   burst_left = 0;
  int   block_left = 0;

  sgpm_audio_if  audio_ch ();
  sgpm_result_if result_ch ();
  sgpm_cfg_if    cfg_ch ();

  smoothed_gain_with_peak_meter_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .audio  (audio_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  sgpm_result_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .audio           (audio_ch),
    .result          (result_ch),
    .cfg             (cfg_ch),
    .mismatch_count  (mismatch_count),
    .words_in_flight (words_in_flight)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin : sink_pacing
    pace_t mode;
    int    span;
    logic  held;
    held = 1'b0;
    result_ch.ready = 1'b0;
    forever begin
      if (hold_long && !held) begin
        held = 1'b1;
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = pace_t'($urandom_range(0, 3));
      span = (mode == PACE_SHUT) ? $urandom_range(1, 40) : $urandom_range(1, 60);
      repeat (span) begin
        case (mode)
          PACE_OPEN:   result_ch.ready <= 1'b1;
          PACE_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
          PACE_SPARSE: result_ch.ready <= ($urandom_range(0, 3) == 0);
          default:     result_ch.ready <= 1'b0;
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2, 3:    return sample_t'(int'($urandom_range(0, 510)) - 255);
      4:       return SAMPLE_MAX - sample_t'($urandom_range(0, 15));
      5:       return SAMPLE_MIN + sample_t'($urandom_range(0, 15));
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic target_t rand_target();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return TARGET_RESET;
      3:       return target_t'($urandom_range(2048, 8192));
      default: return target_t'($urandom);
    endcase
  endfunction

  function automatic decay_t rand_decay();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return decay_t'($urandom_range(0, 4096));
      3:       return decay_t'($urandom_range(0, 300000));
      default: return decay_t'($urandom);
    endcase
  endfunction

  task automatic send_word(input sample_t s, input logic last);
    int gap;
    audio_ch.valid      <= 1'b1;
    audio_ch.sample_in  <= s;
    audio_ch.block_last <= last;
    do @(posedge clk); while (!audio_ch.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      gap        = $urandom_range(0, 16);
      if (gap != 0) begin
        audio_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic wait_drained();
    audio_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input target_t tg, input decay_t dc);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_TARGET_GAIN;
    cfg_ch.data  <= cfg_data_t'(tg);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_DECAY_PER_SAMPLE;
    cfg_ch.data  <= cfg_data_t'(dc);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin : stimulus
    audio_ch.valid      = 1'b0;
    audio_ch.sample_in  = '0;
    audio_ch.block_last = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: unity gain, extremes, one-word block
    send_word('0, 1'b0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(sample_t'(1), 1'b0);
    send_word(sample_t'(-1), 1'b0);
    send_word(sample_t'(-4194304), 1'b1);
    send_word(sample_t'(100), 1'b1);

    // top gain saturates both ways, meter holds with no decay
    wait_drained();
    write_cfg('1, '0);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(SAMPLE_MIN, 1'b0);
    send_word(SAMPLE_MIN + sample_t'(1), 1'b0);
    send_word(sample_t'(12345), 1'b0);
    send_word(sample_t'(-5000000), 1'b1);

    // zero target, full decay
    wait_drained();
    write_cfg('0, '1);
    send_word(SAMPLE_MAX, 1'b0);
    send_word(sample_t'(-3), 1'b0);
    send_word(sample_t'(2000000), 1'b1);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      write_cfg(rand_target(), rand_decay());
      if (p == 2) hold_long <= 1'b1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (block_left == 0)
          block_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 300)
                                                   : $urandom_range(1, 24);
        block_left--;
        send_word(rand_sample(), block_left == 0);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatch_count == 0 && words_in_flight == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/sgpm_pkg.sv
rtl/sgpm_ifs.sv
rtl/sgpm_gain.sv
rtl/sgpm_decay.sv
rtl/smoothed_gain_with_peak_meter_unit.sv
tb/sv/sgpm_result_checker.sv
tb/sv/smoothed_gain_with_peak_meter_unit_tb.sv
